/* sv/uas_pkg.sv */
// Shared types and constants of the undirected adjacency store.
// Used by the controller, the datapath, the top level and the checker.
package uas_pkg;

	localparam int NODES      = 64;
	localparam int MAX_DEGREE = 16;

	localparam int NODE_W    = 6;
	localparam int STATUS_W  = 2;
	localparam int DEG_OUT_W = 5;

	localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
	localparam int ADDR_W  = ((NODES * MAX_DEGREE) > 1) ? $clog2(NODES * MAX_DEGREE) : 1;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_DEL  = 2'd1;
	localparam logic [1:0] MODE_QRY  = 2'd2;
	localparam logic [1:0] MODE_LIST = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [NODE_W-1:0] node_x;
		logic [NODE_W-1:0] node_y;
	} op_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [NODE_W-1:0]    neighbour;
		logic                 neighbour_valid;
		logic [DEG_OUT_W-1:0] degree;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic                load_item;
		logic                deg_rd;
		logic                deg_rd_y;
		logic                cap_dx;
		logic                cap_dy;
		logic                idx_clr;
		logic                idx_inc;
		logic                side_set;
		logic                nt_rd;
		logic                nt_rd_nxt;
		logic                append;
		logic                shift_wr;
		logic                deg_dec;
		logic                set_hit;
		logic                set_st;
		logic [STATUS_W-1:0] st;
		logic                emit;
		logic                emit_nb;
	} uas_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       ok;
		logic       x_ok;
		logic       same;
		logic       hit;
		logic       hit_q;
		logic       idx_end;
		logic       shift_end;
		logic       full;
		logic       side;
		logic       dx_zero;
		logic       list_last;
		logic       out_free;
	} uas_sts_t;

endpackage

/* sv/uas_datapath.sv */
// Datapath of the adjacency store: item registers, degree and neighbour memories,
// list index and the result register. Driven by uas_ctrl; uses uas_pkg.
module uas_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  uas_pkg::op_t     op,
	input  uas_pkg::uas_cmd_t cmd,
	output uas_pkg::uas_sts_t sts,
	output logic             res_valid,
	input  logic             res_stall,
	output uas_pkg::res_t    res
);
	import uas_pkg::*;

	op_t                 item_q;
	logic [DEG_W-1:0]    dx_q, dy_q, idx_q;
	logic                side_q, hit_q;
	logic [STATUS_W-1:0] st_q;
	logic                out_valid_q;
	res_t                out_q;

	logic [DEG_W-1:0]  deg_mem [NODES];
	logic [NODES-1:0]  deg_vld_q;
	logic [DEG_W-1:0]  deg_rdata_q;
	logic              deg_rvld_q;
	logic [NODE_W-1:0] nt_mem [NODES*MAX_DEGREE];
	logic [NODE_W-1:0] nt_rdata_q;

	logic              x_ok, y_ok;
	logic [NODE_W-1:0] row, target;
	logic [DEG_W-1:0]  len, deg_val, idx_nxt;
	logic [ADDR_W-1:0] row_base, nt_raddr, nt_waddr;
	logic [NODE_W-1:0] nt_wdata;
	logic              nt_we, nt_re, deg_we, out_free;
	logic [DEG_W-1:0]  deg_wdata;

	assign x_ok    = 32'(item_q.node_x) < NODES;
	assign y_ok    = 32'(item_q.node_y) < NODES;
	assign row     = side_q ? item_q.node_y : item_q.node_x;
	assign target  = side_q ? item_q.node_x : item_q.node_y;
	assign len     = side_q ? dy_q : dx_q;
	assign deg_val = deg_rvld_q ? deg_rdata_q : '0;
	assign idx_nxt = idx_q + 1'b1;

	assign row_base = ADDR_W'(row) * ADDR_W'(MAX_DEGREE);
	assign nt_raddr = row_base + ADDR_W'(cmd.nt_rd_nxt ? idx_nxt : idx_q);
	assign nt_waddr = row_base + ADDR_W'(cmd.append ? len : idx_q);
	assign nt_wdata = cmd.append ? target : nt_rdata_q;
	assign nt_we    = cmd.append | cmd.shift_wr;
	assign nt_re    = cmd.nt_rd | cmd.nt_rd_nxt;

	assign deg_we    = cmd.append | cmd.deg_dec;
	assign deg_wdata = cmd.append ? len + 1'b1 : len - 1'b1;

	assign out_free = !out_valid_q || !res_stall;

	always_comb begin
		sts.mode      = item_q.mode;
		sts.ok        = x_ok && y_ok;
		sts.x_ok      = x_ok;
		sts.same      = item_q.node_x == item_q.node_y;
		sts.hit       = nt_rdata_q == target;
		sts.hit_q     = hit_q;
		sts.idx_end   = idx_q == len;
		sts.shift_end = idx_nxt >= len;
		sts.full      = (dx_q >= DEG_W'(MAX_DEGREE)) || (dy_q >= DEG_W'(MAX_DEGREE));
		sts.side      = side_q;
		sts.dx_zero   = dx_q == '0;
		sts.list_last = idx_nxt == dx_q;
		sts.out_free  = out_free;
	end

	// neighbour table: one access a cycle, registered read
	always_ff @(posedge clk) begin
		if (nt_we)
			nt_mem[nt_waddr] <= nt_wdata;
		if (nt_re)
			nt_rdata_q <= nt_mem[nt_raddr];
	end

	// degree table; an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (deg_we)
			deg_mem[NODE_AW'(row)] <= deg_wdata;
		if (cmd.deg_rd)
			deg_rdata_q <= deg_mem[NODE_AW'(cmd.deg_rd_y ? item_q.node_y : item_q.node_x)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q  <= '0;
			deg_rvld_q <= 1'b0;
		end else begin
			if (deg_we)
				deg_vld_q[NODE_AW'(row)] <= 1'b1;
			if (cmd.deg_rd)
				deg_rvld_q <= deg_vld_q[NODE_AW'(cmd.deg_rd_y ? item_q.node_y
					: item_q.node_x)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			side_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (cmd.load_item)
				side_q <= 1'b0;
			else if (cmd.side_set)
				side_q <= 1'b1;
			if (cmd.idx_clr) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.idx_inc)
					idx_q <= idx_nxt;
				if (cmd.set_hit)
					hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= op;
		if (cmd.cap_dx)
			dx_q <= x_ok ? deg_val : '0;
		else if (deg_we && !side_q)
			dx_q <= deg_wdata;
		if (cmd.cap_dy)
			dy_q <= deg_val;
		if (cmd.set_st)
			st_q <= cmd.st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit || cmd.emit_nb)
			out_valid_q <= 1'b1;
		else if (!res_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status          <= st_q;
			out_q.neighbour       <= '0;
			out_q.neighbour_valid <= 1'b0;
			out_q.degree          <= x_ok ? DEG_OUT_W'(dx_q) : '0;
			out_q.last            <= 1'b1;
		end else if (cmd.emit_nb) begin
			out_q.status          <= ST_DONE;
			out_q.neighbour       <= nt_rdata_q;
			out_q.neighbour_valid <= 1'b1;
			out_q.degree          <= DEG_OUT_W'(dx_q);
			out_q.last            <= sts.list_last;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

/* sv/uas_ctrl.sv */
// Sequencer of the adjacency store: walks degree reads, list search, shift,
// append and result beats. Commands uas_datapath; uses uas_pkg.
module uas_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_stall,
	input  uas_pkg::uas_sts_t sts,
	output uas_pkg::uas_cmd_t cmd
);
	import uas_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DX   = 4'd1;
	localparam logic [3:0] S_DY   = 4'd2;
	localparam logic [3:0] S_DYW  = 4'd3;
	localparam logic [3:0] S_SRD  = 4'd4;
	localparam logic [3:0] S_SCMP = 4'd5;
	localparam logic [3:0] S_SEND = 4'd6;
	localparam logic [3:0] S_AP   = 4'd7;
	localparam logic [3:0] S_SHR  = 4'd8;
	localparam logic [3:0] S_SHW  = 4'd9;
	localparam logic [3:0] S_SHE  = 4'd10;
	localparam logic [3:0] S_LRD  = 4'd11;
	localparam logic [3:0] S_LEM  = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	logic [3:0] state_q, state_nxt;

	assign op_stall = state_q != S_IDLE;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (op_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = S_DX;
				end
			end
			S_DX: begin
				cmd.deg_rd = 1'b1;
				state_nxt  = S_DY;
			end
			S_DY: begin
				cmd.cap_dx   = 1'b1;
				cmd.deg_rd   = 1'b1;
				cmd.deg_rd_y = 1'b1;
				state_nxt    = S_DYW;
			end
			S_DYW: begin
				cmd.cap_dy  = 1'b1;
				cmd.idx_clr = 1'b1;
				if (sts.mode == MODE_LIST) begin
					if (sts.dx_zero) begin
						cmd.set_st = 1'b1;
						cmd.st     = sts.x_ok ? ST_DONE : ST_NOT;
						state_nxt  = S_OUT;
					end else begin
						state_nxt = S_LRD;
					end
				end else if (!sts.ok) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_NOT;
					state_nxt  = S_OUT;
				end else begin
					state_nxt = S_SRD;
				end
			end
			S_SRD: begin
				if (sts.idx_end) begin
					state_nxt = S_SEND;
				end else begin
					cmd.nt_rd = 1'b1;
					state_nxt = S_SCMP;
				end
			end
			S_SCMP: begin
				if (sts.hit) begin
					cmd.set_hit = 1'b1;
					state_nxt   = S_SEND;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = S_SRD;
				end
			end
			S_SEND: begin
				if (sts.side) begin
					// second half of a remove: x is already gone
					if (sts.hit_q) begin
						state_nxt = S_SHR;
					end else begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_DONE;
						state_nxt  = S_OUT;
					end
				end else begin
					case (sts.mode)
						MODE_ADD: begin
							if (sts.same || sts.hit_q) begin
								cmd.set_st = 1'b1;
								cmd.st     = ST_NOT;
								state_nxt  = S_OUT;
							end else if (sts.full) begin
								cmd.set_st = 1'b1;
								cmd.st     = ST_FULL;
								state_nxt  = S_OUT;
							end else begin
								state_nxt = S_AP;
							end
						end
						MODE_DEL: begin
							if (sts.hit_q) begin
								state_nxt = S_SHR;
							end else begin
								cmd.set_st = 1'b1;
								cmd.st     = ST_NOT;
								state_nxt  = S_OUT;
							end
						end
						default: begin
							cmd.set_st = 1'b1;
							cmd.st     = sts.hit_q ? ST_DONE : ST_NOT;
							state_nxt  = S_OUT;
						end
					endcase
				end
			end
			S_AP: begin
				cmd.append = 1'b1;
				if (sts.side) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_DONE;
					state_nxt  = S_OUT;
				end else begin
					cmd.side_set = 1'b1;
				end
			end
			S_SHR: begin
				if (sts.shift_end) begin
					state_nxt = S_SHE;
				end else begin
					cmd.nt_rd_nxt = 1'b1;
					state_nxt     = S_SHW;
				end
			end
			S_SHW: begin
				cmd.shift_wr = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_nxt    = S_SHR;
			end
			S_SHE: begin
				cmd.deg_dec = 1'b1;
				if (sts.side) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_DONE;
					state_nxt  = S_OUT;
				end else begin
					cmd.side_set = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_nxt    = S_SRD;
				end
			end
			S_LRD: begin
				cmd.nt_rd = 1'b1;
				state_nxt = S_LEM;
			end
			S_LEM: begin
				if (sts.out_free) begin
					cmd.emit_nb = 1'b1;
					if (sts.list_last) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt   = S_LRD;
					end
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

/* sv/undirected_adjacency_store.sv */
// Undirected graph store: per-node ordered neighbour lists with degree counts.
// Top level; joins uas_ctrl and uas_datapath, types from uas_pkg.
//
// One operation is taken at a time; op_stall stays high until its last result
// beat has been loaded into the output register. The neighbour table is a
// single-port memory with one access per cycle, so an operation walks its
// steps in order: the degree reads of node_x and node_y, a search of node_x's
// list (and of node_y's on a remove), a shift of the entries behind a removed
// one, an append to both lists on an add, one read per entry listed, and the
// result. Each result beat also waits while an earlier beat is held in the
// output register by res_stall. The degree store resets to zero through
// per-node valid bits, so no clearing pass is needed after reset.
module undirected_adjacency_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_stall,
	input  uas_pkg::op_t  op,
	output logic          res_valid,
	input  logic          res_stall,
	output uas_pkg::res_t res
);
	import uas_pkg::*;

	uas_cmd_t cmd;
	uas_sts_t sts;

	uas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	uas_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

/* sv/uas_checker.sv */
// Port-level checks on the adjacency store, bound to its top level.
// Depends on uas_pkg for the beat types and limits.
module uas_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          op_valid,
	input logic          op_stall,
	input uas_pkg::op_t  op,
	input logic          res_valid,
	input logic          res_stall,
	input uas_pkg::res_t res
);
	import uas_pkg::*;

	// a held result beat keeps its contents
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	// one operation at a time: no second beat straight after an accepted one
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_stall |=> op_stall)
		else $error("input taken while an operation is in flight");

	// a beat without a neighbour carries zero and closes its operation
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.neighbour_valid |-> res.last && res.neighbour == '0)
		else $error("beat without neighbour is malformed");

	a_status_deg: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status <= ST_FULL && 32'(res.degree) <= MAX_DEGREE)
		else $error("status code or degree out of range");

	// listing beats report success
	a_list_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.neighbour_valid |-> res.status == ST_DONE)
		else $error("neighbour beat with failing status");

endmodule

bind undirected_adjacency_store uas_checker u_uas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.op_valid  (op_valid),
	.op_stall  (op_stall),
	.op        (op),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

/* verif/tb_undirected_adjacency_store.sv */
// Self-checking testbench for undirected_adjacency_store: directed, random and
// back-pressure operations checked beat by beat against an in-bench graph model.
// Depends on uas_pkg for the operation and result beat types and the mode codes.
module tb_undirected_adjacency_store;
	timeunit 1ns;
	timeprecision 1ps;

	import uas_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 4 * MAX_DEGREE + 16;

	logic clk;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	op_t  op;
	logic res_valid;
	logic res_stall;
	res_t res;

	undirected_adjacency_store dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op        (op),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// graph model
	int                deg_of [NODES];
	logic [NODE_W-1:0] adj [NODES][MAX_DEGREE];
	res_t              expected_beats[$];

	int   err_count;
	int   items_sent;
	int   beats_checked;
	int   ops_by_mode [4];
	int   full_refusals;
	int   peak_degree;
	int   quiet_cycles;
	logic no_idle;
	logic hold_req;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int find_entry(int n, logic [NODE_W-1:0] v);
		for (int i = 0; i < deg_of[n]; i++)
			if (adj[n][i] == v)
				return i;
		return -1;
	endfunction

	// delete v from n's list, closing the gap so order is kept
	function automatic void drop_entry(int n, logic [NODE_W-1:0] v);
		int p;
		p = find_entry(n, v);
		if (p < 0)
			return;
		for (int i = p; i + 1 < deg_of[n]; i++)
			adj[n][i] = adj[n][i + 1];
		deg_of[n]--;
	endfunction

	function automatic res_t make_beat(logic [STATUS_W-1:0] st, logic [NODE_W-1:0] nb,
			logic nv, int deg, logic lst);
		res_t b;
		b.status          = st;
		b.neighbour       = nb;
		b.neighbour_valid = nv;
		b.degree          = DEG_OUT_W'(deg);
		b.last            = lst;
		return b;
	endfunction

	function automatic void apply_graph_op(op_t o);
		int                  x;
		int                  y;
		logic                x_in;
		logic                y_in;
		logic [STATUS_W-1:0] st;
		x    = int'(o.node_x);
		y    = int'(o.node_y);
		x_in = (x < NODES);
		y_in = (y < NODES);
		st   = ST_NOT;
		ops_by_mode[o.mode]++;
		if (o.mode == MODE_LIST) begin
			if (!x_in)
				expected_beats.push_back(make_beat(ST_NOT, '0, 1'b0, 0, 1'b1));
			else if (deg_of[x] == 0)
				expected_beats.push_back(make_beat(ST_DONE, '0, 1'b0, 0, 1'b1));
			else
				for (int i = 0; i < deg_of[x]; i++)
					expected_beats.push_back(make_beat(ST_DONE, adj[x][i], 1'b1, deg_of[x],
						i == deg_of[x] - 1));
			return;
		end
		if (x_in && y_in) begin
			case (o.mode)
				MODE_ADD: begin
					if (x != y && find_entry(x, o.node_y) < 0) begin
						if (deg_of[x] >= MAX_DEGREE || deg_of[y] >= MAX_DEGREE) begin
							st = ST_FULL;
							full_refusals++;
						end else begin
							adj[x][deg_of[x]] = o.node_y;
							deg_of[x]++;
							adj[y][deg_of[y]] = o.node_x;
							deg_of[y]++;
							st = ST_DONE;
							if (deg_of[x] > peak_degree) peak_degree = deg_of[x];
							if (deg_of[y] > peak_degree) peak_degree = deg_of[y];
						end
					end
				end
				MODE_DEL: begin
					if (find_entry(x, o.node_y) >= 0) begin
						drop_entry(x, o.node_y);
						drop_entry(y, o.node_x);
						st = ST_DONE;
					end
				end
				default: begin
					st = (find_entry(x, o.node_y) >= 0) ? ST_DONE : ST_NOT;
				end
			endcase
		end
		expected_beats.push_back(make_beat(st, '0, 1'b0, x_in ? deg_of[x] : 0, 1'b1));
	endfunction

	task automatic send_op(input logic [1:0] m, input logic [NODE_W-1:0] x,
			input logic [NODE_W-1:0] y);
		int  gap;
		op_t o;
		gap      = no_idle ? 0 : $urandom_range(0, 5);
		o.mode   = m;
		o.node_x = x;
		o.node_y = y;
		@(negedge clk);
		if (gap > 0) begin
			op_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op       = o;
		op_valid = 1'b1;
		do @(posedge clk); while (op_stall);
		apply_graph_op(o);
		items_sent++;
	endtask

	task automatic test_basic_edges();
		send_op(MODE_LIST, 6'd0, 6'd0);     // empty list
		send_op(MODE_QRY, 6'd0, 6'd63);     // absent edge
		send_op(MODE_ADD, 6'd5, 6'd5);      // self loop refused
		send_op(MODE_ADD, 6'd0, 6'd63);
		send_op(MODE_ADD, 6'd63, 6'd0);     // already there, other direction
		send_op(MODE_ADD, 6'd0, 6'd1);
		send_op(MODE_QRY, 6'd63, 6'd0);
		send_op(MODE_DEL, 6'd0, 6'd63);     // head entry, later one shifts down
		send_op(MODE_DEL, 6'd0, 6'd63);     // now absent
		send_op(MODE_LIST, 6'd0, 6'd63);
	endtask

	task automatic test_full_list();
		for (int k = 0; k < MAX_DEGREE; k++)
			send_op(MODE_ADD, 6'd63, NODE_W'(10 + k));
		send_op(MODE_ADD, 6'd63, 6'd40);    // first node full
		send_op(MODE_ADD, 6'd41, 6'd63);    // second node full
		send_op(MODE_LIST, 6'd63, 6'd0);
		send_op(MODE_DEL, 6'd63, 6'd10);    // shift the whole list
	endtask

	task automatic test_random_ops(input int n_items);
		int         hub;
		int         base;
		int         x;
		int         y;
		int         pick;
		int         m;
		logic [1:0] md;
		hub  = $urandom_range(0, NODES - 1);
		base = $urandom_range(0, NODES - 1);
		for (int i = 0; i < n_items; i++) begin
			if (i % 30 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			// keep most traffic on a hub and a small node window so lists grow
			pick = $urandom_range(0, 99);
			if (pick < 25)
				x = hub;
			else if (pick < 80)
				x = (base + $urandom_range(0, 15)) % NODES;
			else
				x = $urandom_range(0, 63);
			m  = $urandom_range(0, 99);
			md = (m < 45) ? MODE_ADD : (m < 65) ? MODE_DEL : (m < 85) ? MODE_QRY : MODE_LIST;
			pick = $urandom_range(0, 99);
			if (md != MODE_ADD && x < NODES && deg_of[x] > 0 && pick < 60)
				y = int'(adj[x][$urandom_range(0, deg_of[x] - 1)]);
			else if (pick < 5)
				y = x;
			else if (pick < 70)
				y = (base + $urandom_range(0, 15)) % NODES;
			else
				y = $urandom_range(0, 63);
			send_op(md, NODE_W'(x), NODE_W'(y));
		end
		no_idle = 1'b0;
	endtask

	// receiver holds off while ops keep coming, so the block backs up
	task automatic test_result_backpressure();
		@(posedge clk);
		hold_req = 1'b1;
		no_idle  = 1'b1;
		for (int i = 0; i < 12; i++)
			send_op((i % 3 == 0) ? MODE_LIST : MODE_ADD,
				NODE_W'($urandom_range(0, NODES - 1)), NODE_W'($urandom_range(0, NODES - 1)));
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		op_valid      = 1'b0;
		op            = '0;
		no_idle       = 1'b0;
		hold_req      = 1'b0;
		err_count     = 0;
		items_sent    = 0;
		beats_checked = 0;
		full_refusals = 0;
		peak_degree   = 0;
		for (int i = 0; i < 4; i++)
			ops_by_mode[i] = 0;
		for (int n = 0; n < NODES; n++)
			deg_of[n] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_edges();
		test_full_list();
		test_random_ops(145);
		test_result_backpressure();

		@(negedge clk);
		op_valid = 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d ops (add %0d, remove %0d, query %0d, list %0d), %0d beats checked",
			items_sent, ops_by_mode[MODE_ADD], ops_by_mode[MODE_DEL], ops_by_mode[MODE_QRY],
			ops_by_mode[MODE_LIST], beats_checked);
		$display("%0d adds refused on a full list, highest degree reached %0d",
			full_refusals, peak_degree);
		if (err_count == 0) begin
			$display("tb_undirected_adjacency_store: done, clean");
		end else begin
			$display("tb_undirected_adjacency_store: done, errors");
		end
		$finish;
	end

	// result side: random stall per beat, plus the long hold on request
	initial begin
		int   wait_left;
		int   hold_left;
		logic took;
		res_stall = 1'b0;
		wait_left = 0;
		hold_left = 0;
		@(negedge clk);
		forever begin
			@(posedge clk);
			took = res_valid && !res_stall;
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (took)
				wait_left = no_idle ? 0 : $urandom_range(0, 5);
			if (hold_left > 0) begin
				hold_left--;
				res_stall = 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				res_stall = 1'b1;
			end else begin
				res_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected: %p", res);
				err_count++;
			end else begin
				want = expected_beats.pop_front();
				beats_checked++;
				if (res.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res.status);
					err_count++;
				end
				if (res.neighbour !== want.neighbour) begin
					$error("neighbour: expected %0d, got %0d", want.neighbour, res.neighbour);
					err_count++;
				end
				if (res.neighbour_valid !== want.neighbour_valid) begin
					$error("neighbour_valid: expected %0d, got %0d", want.neighbour_valid,
						res.neighbour_valid);
					err_count++;
				end
				if (res.degree !== want.degree) begin
					$error("degree: expected %0d, got %0d", want.degree, res.degree);
					err_count++;
				end
				if (res.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, res.last);
					err_count++;
				end
			end
		end
	end

	// end the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (op_valid && !op_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_undirected_adjacency_store: done, errors");
			$finish;
		end
	end

endmodule
